// ===== sv/gamma2_alpha_over_blend_defines.svh =====
// ----------------------------------------------------------------------------
// gamma2 alpha-over blend assertion macros
// shared concurrent assertion forms for the blend checker
// ----------------------------------------------------------------------------
`ifndef GAMMA2_ALPHA_OVER_BLEND_DEFINES_SVH
`define GAMMA2_ALPHA_OVER_BLEND_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define GAB_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gab assertion failed");

// same, on the checker's own clk and rst_n
`define GAB_ASSERT(label, prop) `GAB_ASSERT_CLK(label, clk, rst_n, prop)

`endif

// ===== sv/gab_pkg.sv =====
// ----------------------------------------------------------------------------
// gab_pkg
// constants and table functions shared by the gamma2 alpha-over blend
// ----------------------------------------------------------------------------
package gab_pkg;

  localparam int LINEAR_FRAC_BITS_DEF = 16;
  localparam int CH_W = 8;
  localparam int CA_W = 9;
  localparam int NUM_COLOUR = 3;
  localparam int TAB_DEPTH = 256;
  localparam logic [CA_W-1:0] CA_ONE = 9'd256;

  // colour byte to linear: (c/255)^2, rounded
  function automatic longint lin_colour_f(input int c, input int f);
    longint one;
    longint cc;
    one = longint'(1) << f;
    cc = longint'(c);
    return (2 * cc * cc * one + 65025) / 130050;
  endfunction

  // alpha byte to linear: a/255, rounded
  function automatic longint lin_alpha_f(input int a, input int f);
    longint one;
    one = longint'(1) << f;
    return (2 * longint'(a) * one + 255) / 510;
  endfunction

  // smallest linear value that encodes to at least k
  function automatic longint enc_thr_f(input int k, input int f);
    longint one;
    longint odd;
    longint res;
    one = longint'(1) << f;
    odd = 2 * longint'(k) - 1;
    if (k == 0) begin
      res = 0;
    end else begin
      res = (odd * odd * one + 260099) / 260100;
    end
    return res;
  endfunction

endpackage

// ===== sv/gab_lane.sv =====
// ----------------------------------------------------------------------------
// gab_lane
// one channel lane: opacity scale, over-blend multiply, round and shift
// ----------------------------------------------------------------------------
module gab_lane
  import gab_pkg::*;
#(
  parameter int LINEAR_FRAC_BITS = LINEAR_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [LINEAR_FRAC_BITS:0]   s_lin,
  input  logic [LINEAR_FRAC_BITS:0]   d_lin,
  input  logic [CA_W-1:0]             ca,
  input  logic [LINEAR_FRAC_BITS:0]   sa,
  output logic [LINEAR_FRAC_BITS:0]   s_sc,
  output logic [LINEAR_FRAC_BITS+1:0] r
);

  localparam int LW = LINEAR_FRAC_BITS + 1;
  localparam int SW = LW + CA_W;
  localparam int PW = 2 * LW;
  localparam logic [LW-1:0] ONE = LW'(1) << LINEAR_FRAC_BITS;

  logic [SW-1:0]   sc_sum;
  logic [LW-1:0]   s_sc_r, s_sc_nxt;
  logic [LW-1:0]   d1_r;
  logic [LW-1:0]   om;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [LW-1:0]   s2_r;
  logic [PW-1:0]   bl_sum;
  logic [LW:0]     r_r, r_nxt;

  // stage 1: source times opacity, rounded
  assign sc_sum   = SW'(s_lin) * SW'(ca) + SW'(128);
  assign s_sc_nxt = sc_sum[LINEAR_FRAC_BITS+8:8];

  // stage 2: (1 - sa) * dest
  assign om       = ONE - sa;
  assign prod_nxt = PW'(om) * PW'(d1_r);

  // stage 3: add source, round, drop fraction
  assign bl_sum = prod_r + (PW'(s2_r) << LINEAR_FRAC_BITS) + PW'(ONE >> 1);
  assign r_nxt  = bl_sum[2*LINEAR_FRAC_BITS+1:LINEAR_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      s_sc_r <= s_sc_nxt;
      d1_r   <= d_lin;
      prod_r <= prod_nxt;
      s2_r   <= s_sc_r;
      r_r    <= r_nxt;
    end
  end

  assign s_sc = s_sc_r;
  assign r    = r_r;

endmodule

// ===== sv/gab_enc.sv =====
// ----------------------------------------------------------------------------
// gab_enc
// colour re-encode: 255*sqrt(x) rounded, as a two-stage binary search
// ----------------------------------------------------------------------------
module gab_enc
  import gab_pkg::*;
#(
  parameter int LINEAR_FRAC_BITS = LINEAR_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [LINEAR_FRAC_BITS+1:0] x,
  output logic [CH_W-1:0]             code
);

  localparam int LW = LINEAR_FRAC_BITS + 1;
  localparam int XW = LINEAR_FRAC_BITS + 2;
  localparam int HALF = CH_W / 2;

  logic [LW-1:0]     thr_tab [TAB_DEPTH];
  logic [CH_W-1:0]   na, na_cand;
  logic [CH_W-1:0]   nb, nb_cand;
  logic [HALF-1:0]   na_r;
  logic [XW-1:0]     xa_r;
  logic [CH_W-1:0]   code_r;

  for (genvar k = 0; k < TAB_DEPTH; k++) begin : g_thr
    assign thr_tab[k] = LW'(enc_thr_f(k, LINEAR_FRAC_BITS));
  end

  // upper bits of the code
  always_comb begin
    na      = '0;
    na_cand = '0;
    for (int b = CH_W - 1; b >= HALF; b--) begin
      na_cand = na | (CH_W'(1) << b);
      if (x >= XW'(thr_tab[na_cand])) na = na_cand;
    end
  end

  // lower bits of the code
  always_comb begin
    nb      = {na_r, HALF'(0)};
    nb_cand = '0;
    for (int b = HALF - 1; b >= 0; b--) begin
      nb_cand = nb | (CH_W'(1) << b);
      if (xa_r >= XW'(thr_tab[nb_cand])) nb = nb_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r   <= na[CH_W-1:HALF];
      xa_r   <= x;
      code_r <= nb;
    end
  end

  assign code = code_r;

endmodule

// ===== sv/gamma2_alpha_over_blend.sv =====
// ----------------------------------------------------------------------------
// gamma2_alpha_over_blend
// premultiplied over blend of an RGBA source onto an RGBA destination in a
// gamma-2 linear space, with a global source opacity
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+--------------
//  in      | in_src_pixel, in_dest_pixel             | in  | valid / ready
//  out     | out_pixel                               | out | valid / ready
//  cfg     | cfg_const_alpha                         | in  | cfg_we only
//
//  one word per clock while the output is not stalled; five register stages:
//  opacity multiply, blend multiply, blend add, then the upper and lower
//  halves of the square-root search in the colour encoder
//  in_ready = !out_valid || out_ready: the whole pipe advances together and
//  holds on an output stall, bubbles pass through with their valid bit low
//  reset clears all valid bits and sets const_alpha to 1.0 (256)
//
module gamma2_alpha_over_blend
  import gab_pkg::*;
#(
  parameter int LINEAR_FRAC_BITS = LINEAR_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      in_src_pixel,
  input  logic [31:0]      in_dest_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_pixel,
  input  logic             cfg_we,
  input  logic [CA_W-1:0]  cfg_const_alpha
);

  localparam int LW = LINEAR_FRAC_BITS + 1;
  localparam int RW = LINEAR_FRAC_BITS + 2;
  localparam int AW = LINEAR_FRAC_BITS + 10;
  localparam int DEPTH = 5;
  localparam logic [LW-1:0] ONE = LW'(1) << LINEAR_FRAC_BITS;

  // linearization tables, constant logic
  logic [LW-1:0]    lin_c_tab [TAB_DEPTH];
  logic [LW-1:0]    lin_a_tab [TAB_DEPTH];

  logic             adv;
  logic [DEPTH-1:0] v_r, v_nxt;
  logic [CA_W-1:0]  ca_r;

  // per-lane wiring: lanes 0..2 colour, lane 3 alpha
  logic [LW-1:0]    s_lin [4];
  logic [LW-1:0]    d_lin [4];
  logic [RW-1:0]    r_w   [4];
  logic [LW-1:0]    sa;
  logic [CH_W-1:0]  c_code [NUM_COLOUR];

  // alpha encode
  logic [AW-1:0]    a_mul;
  logic [AW-LINEAR_FRAC_BITS-1:0] a_q;
  logic [CH_W-1:0]  a4_r, a4_nxt;
  logic [CH_W-1:0]  a5_r;

  for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_tab
    assign lin_c_tab[i] = LW'(lin_colour_f(i, LINEAR_FRAC_BITS));
    assign lin_a_tab[i] = LW'(lin_alpha_f(i, LINEAR_FRAC_BITS));
  end

  // ---- pipeline control ----
  // every stage moves when the output word is taken or absent
  assign adv      = !v_r[DEPTH-1] || out_ready;
  assign in_ready = adv;
  assign v_nxt    = {v_r[DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  // ---- opacity register, saturated to 1.0 on write ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= CA_ONE;
    end else if (cfg_we) begin
      ca_r <= (cfg_const_alpha > CA_ONE) ? CA_ONE : cfg_const_alpha;
    end
  end

  // ---- table lookups straight off the input word ----
  for (genvar i = 0; i < NUM_COLOUR; i++) begin : g_lut
    assign s_lin[i] = lin_c_tab[in_src_pixel[CH_W*i +: CH_W]];
    assign d_lin[i] = lin_c_tab[in_dest_pixel[CH_W*i +: CH_W]];
  end
  assign s_lin[3] = lin_a_tab[in_src_pixel[31:24]];
  assign d_lin[3] = lin_a_tab[in_dest_pixel[31:24]];

  // ---- alpha lane: its scaled source alpha drives every lane's blend ----
  gab_lane #(
    .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS)
  ) u_lane_a (
    .clk   (clk),
    .en    (adv),
    .s_lin (s_lin[3]),
    .d_lin (d_lin[3]),
    .ca    (ca_r),
    .sa    (sa),
    .s_sc  (sa),
    .r     (r_w[3])
  );

  // ---- colour lanes with their square-root encoders ----
  for (genvar i = 0; i < NUM_COLOUR; i++) begin : g_col
    gab_lane #(
      .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (adv),
      .s_lin (s_lin[i]),
      .d_lin (d_lin[i]),
      .ca    (ca_r),
      .sa    (sa),
      .s_sc  (),
      .r     (r_w[i])
    );

    gab_enc #(
      .LINEAR_FRAC_BITS (LINEAR_FRAC_BITS)
    ) u_enc (
      .clk  (clk),
      .en   (adv),
      .x    (r_w[i]),
      .code (c_code[i])
    );
  end

  // ---- alpha encode: 255*x rounded, saturated; then a4_r and a5_r to line up ----
  assign a_mul  = (AW'(r_w[3]) << 8) - AW'(r_w[3]) + AW'(ONE >> 1);
  assign a_q    = a_mul[AW-1:LINEAR_FRAC_BITS];
  assign a4_nxt = (a_q > (AW-LINEAR_FRAC_BITS)'(255)) ? 8'hFF : a_q[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      a4_r <= a4_nxt;
      a5_r <= a4_r;
    end
  end

  // ---- merge: lane bytes packed into the result word ----
  assign out_valid = v_r[DEPTH-1];
  assign out_pixel = {a5_r, c_code[2], c_code[1], c_code[0]};

endmodule

// ===== sv/gab_checker.sv =====
// ----------------------------------------------------------------------------
// gab_checker
// port-level checks on the blend's output stall and ready behavior
// ----------------------------------------------------------------------------
`include "gamma2_alpha_over_blend_defines.svh"

module gab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel
);

  // stalled word stays
  `GAB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `GAB_ASSERT(a_pix_hold, out_valid && !out_ready |=> $stable(out_pixel))
  // a word leaving frees a slot in the same cycle
  `GAB_ASSERT(a_ready_drain, out_valid && out_ready |-> in_ready)
  // input backs off only on an output stall
  `GAB_ASSERT(a_stall_only, !in_ready |-> out_valid && !out_ready)

endmodule

bind gamma2_alpha_over_blend gab_checker u_gab_checker (.*);

// ===== bench/gab_blend_checker.sv =====
// ----------------------------------------------------------------------------
// gab_blend_checker
// watches the pixel channels of the gamma-2 over blend, predicts each blended
// word from the accepted source and destination, and counts mismatches
// ----------------------------------------------------------------------------
module gab_blend_checker
  import gab_pkg::*;
#(
  parameter int LINEAR_FRAC_BITS = LINEAR_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [31:0]     in_src_pixel,
  input  logic [31:0]     in_dest_pixel,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [31:0]     out_pixel,
  input  logic            cfg_we,
  input  logic [CA_W-1:0] cfg_const_alpha,
  output int              mismatch_count,
  output int              words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]     expected_pixels [$];
  logic [CA_W-1:0] opacity = CA_ONE;
  logic [31:0]     want;
  int              errs = 0;

  // (c/255)^2 in Q1.F
  function automatic logic [63:0] colour_to_linear(input logic [7:0] c);
    logic [63:0] cc;
    cc = {56'd0, c};
    return (64'd2 * cc * cc * (64'd1 << LINEAR_FRAC_BITS) + 64'd65025) / 64'd130050;
  endfunction

  // a/255 in Q1.F
  function automatic logic [63:0] alpha_to_linear(input logic [7:0] a);
    logic [63:0] aa;
    aa = {56'd0, a};
    return (64'd2 * aa * (64'd1 << LINEAR_FRAC_BITS) + 64'd255) / 64'd510;
  endfunction

  function automatic logic [31:0] blend_over(input logic [31:0] src, input logic [31:0] dst,
                                             input logic [CA_W-1:0] ca);
    logic [63:0] one;
    logic [63:0] s [4];
    logic [63:0] d [4];
    logic [63:0] r;
    logic [63:0] rhs;
    logic [63:0] odd;
    logic [63:0] v;
    logic [7:0]  n;
    logic [31:0] pix;
    one = 64'd1 << LINEAR_FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      s[i] = colour_to_linear(src[8*i +: 8]);
      d[i] = colour_to_linear(dst[8*i +: 8]);
    end
    s[3] = alpha_to_linear(src[31:24]);
    d[3] = alpha_to_linear(dst[31:24]);
    for (int i = 0; i < 4; i++) begin
      s[i] = (s[i] * {55'd0, ca} + 64'd128) >> 8;
    end
    pix = '0;
    for (int i = 0; i < 4; i++) begin
      r = ((one - s[3]) * d[i] + s[i] * one + (one >> 1)) >> LINEAR_FRAC_BITS;
      if (i < 3) begin
        // largest n with (2n-1)^2 * one <= 260100 * r, the test is monotone in n
        rhs = 64'd260100 * r;
        n = 8'd0;
        for (int k = 1; k <= 255; k++) begin
          odd = 64'(2 * k - 1);
          if (odd * odd * one <= rhs) n = k[7:0];
        end
        pix[8*i +: 8] = n;
      end else begin
        v = (64'd510 * r + one) / (64'd2 * one);
        pix[31:24] = (v > 64'd255) ? 8'hFF : v[7:0];
      end
    end
    return pix;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_pixels.delete();
      opacity = CA_ONE;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected out word %08h", out_pixel);
        end else begin
          want = expected_pixels.pop_front();
          if (want !== out_pixel) begin
            errs++;
            if (errs <= 10) $display("mismatch: expected %08h got %08h", want, out_pixel);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_pixels.push_back(blend_over(in_src_pixel, in_dest_pixel, opacity));
      end
      // opacity above one saturates
      if (cfg_we) opacity = (cfg_const_alpha > CA_ONE) ? CA_ONE : cfg_const_alpha;
    end
    mismatch_count  <= errs;
    words_in_flight <= expected_pixels.size();
  end

endmodule

// ===== bench/gamma2_alpha_over_blend_tb.sv =====
// ----------------------------------------------------------------------------
// gamma2_alpha_over_blend_tb
// drives source/destination pixel words into the blend under random gaps and
// output stalls, sweeps the global opacity across its range, and reports the
// verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module gamma2_alpha_over_blend_tb
  import gab_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT      = 400000;  // far beyond the slowest legal run
  localparam int DRAIN_CYCLES     = 20;      // pipe is 5 deep, leave margin
  localparam int LONG_HOLD        = 300;     // receiver hold-off to fill the pipe
  localparam int RANDOM_PER_PHASE = 140;
  localparam int NUM_PHASES       = 9;

  // every block input starts at a known value
  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [31:0]     in_src_pixel = '0;
  logic [31:0]     in_dest_pixel = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [31:0]     out_pixel;
  logic            cfg_we = 1'b0;
  logic [CA_W-1:0] cfg_const_alpha = '0;

  int mismatch_count;
  int words_in_flight;
  int cycles = 0;

  // steady flags give stretches with no idling on either side
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_off_req = 1'b0;

  // opacity per phase: reset value first, then the extremes and beyond one;
  // the last phase draws a random setting
  logic [CA_W-1:0] phase_opacity [NUM_PHASES] =
    '{9'd256, 9'd0, 9'h1FF, 9'd1, 9'd128, 9'd257, 9'd255, 9'd256, 9'd0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gamma2_alpha_over_blend dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_src_pixel   (in_src_pixel),
    .in_dest_pixel  (in_dest_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .cfg_we         (cfg_we),
    .cfg_const_alpha(cfg_const_alpha)
  );

  gab_blend_checker blend_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_src_pixel   (in_src_pixel),
    .in_dest_pixel  (in_dest_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .cfg_we         (cfg_we),
    .cfg_const_alpha(cfg_const_alpha),
    .mismatch_count (mismatch_count),
    .words_in_flight(words_in_flight)
  );

  // offer one pixel pair; called at a falling edge, returns at a falling edge
  // after the word has been taken. with no gap, valid simply stays high and
  // only the payload moves on
  task automatic offer_word(input logic [31:0] src, input logic [31:0] dst);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_src_pixel  = src;
    in_dest_pixel = dst;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // well-formed premultiplied pixels (colour at or below alpha), as often as raw
  // noise, plus saturated bytes and fully opaque or fully clear alpha
  function automatic logic [31:0] random_pixel();
    logic [7:0]  a;
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(0, 5))
      0, 1: begin
        p = $urandom;
      end
      2, 3: begin
        a = 8'($urandom);
        p[31:24] = a;
        for (int i = 0; i < 3; i++) p[8*i +: 8] = 8'($urandom_range(0, a));
      end
      4: begin
        for (int i = 0; i < 4; i++) begin
          if ($urandom_range(0, 2) != 0) p[8*i +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        end
      end
      default: begin
        p[31:24] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
    endcase
    return p;
  endfunction

  // receiver: random stall before each word, with an occasional long hold-off
  // that lets the pipe fill while the sender keeps offering
  initial begin
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = rx_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // opacity is only written with the pipe empty; phase 0 runs on reset value
      if (ph > 0) begin
        in_valid = 1'b0;
        while (words_in_flight != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_const_alpha = (ph == NUM_PHASES - 1) ? 9'($urandom_range(0, 511))
                                                 : phase_opacity[ph];
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
      end

      tx_steady = (ph == 1) || ($urandom_range(0, 3) == 0);
      rx_steady = (ph == 1) || ($urandom_range(0, 3) == 0);
      if (ph == 2 || ph == 6) hold_off_req = 1'b1;

      if (ph == 0) begin
        // all-zero and all-one fields
        offer_word(32'h0000_0000, 32'h0000_0000);
        offer_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_word(32'hFFFF_FFFF, 32'h0000_0000);
        offer_word(32'h0000_0000, 32'hFFFF_FFFF);
        // colour above alpha: sum goes past one and saturates
        offer_word(32'h00FF_FFFF, 32'hFFFF_FFFF);
        offer_word(32'h00FF_FFFF, 32'h0000_0000);
        offer_word(32'h01FF_FFFF, 32'h8080_8080);
        offer_word(32'h80FF_FFFF, 32'hFFFF_FFFF);
        // mid-scale rounding around half
        offer_word(32'h8080_8080, 32'h7F7F_7F7F);
        offer_word(32'h7F7F_7F7F, 32'h8080_8080);
        offer_word(32'h0101_0101, 32'hFEFE_FEFE);
        // channels differ, order must not matter
        offer_word(32'hFF12_3456, 32'h00AB_CDEF);
        offer_word(32'h8040_2010, 32'hFF10_2040);
        offer_word(32'hFF00_00FF, 32'h0000_FF00);
        offer_word(32'hFE00_0000, 32'h00FF_FFFF);
        // alternating bit patterns
        offer_word(32'hAAAA_AAAA, 32'h5555_5555);
        offer_word(32'h5555_5555, 32'hAAAA_AAAA);
        offer_word(32'h4040_4040, 32'hC0C0_C0C0);
      end else begin
        // field extremes under each opacity setting
        offer_word(32'h0000_0000, 32'hFFFF_FFFF);
        offer_word(32'hFFFF_FFFF, 32'h0000_0000);
        offer_word(32'h00FF_FFFF, 32'hFFFF_FFFF);
        offer_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end

      for (int j = 0; j < RANDOM_PER_PHASE; j++) begin
        // reshuffle idling mode now and then so stretches vary within a phase
        if (j % 40 == 39) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        offer_word(random_pixel(), random_pixel());
      end
    end

    in_valid = 1'b0;
    while (words_in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
